// ===== src/fvsc_pkg.sv =====
package fvsc_pkg;

    localparam int MAX_NODES_DEF = 64;

    localparam int FLAG_W     = 64;
    localparam int PROP_W     = 31;
    localparam int SLOT_W     = 12;
    localparam int RAND_W     = 16;
    localparam int DTC_W      = 8;
    localparam int MISS_W     = 4;
    localparam int NODES_W    = 7;
    localparam int INDEX_W    = 6;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 192;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    // bit positions in the result word that the checker looks at
    localparam int OUT_COMPLETE_BIT = 162;
    localparam int OUT_XMIT_BIT     = 176;

    localparam logic [NODES_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic [SLOT_W-1:0]  MAX_SLOTS_RST  = 12'd4095;
    localparam logic [DTC_W-1:0]   TX_TARGET_RST  = 8'd9;
    localparam logic [MISS_W-1:0]  RESTART_RST    = 4'd6;
    localparam logic [DTC_W-1:0]   DTC_MAX        = 8'hFF;
    localparam logic [MISS_W-1:0]  MISS_MAX       = 4'hF;

    typedef enum logic [1:0] {
        SLOT_INIT = 2'd0,
        SLOT_RX   = 2'd1,
        SLOT_TX   = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        NEXT_RX  = 2'd0,
        NEXT_TX  = 2'd1,
        NEXT_OFF = 2'd2
    } next_mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IS_INITIATOR = 3'd0,
        CFG_NODE_COUNT   = 3'd1,
        CFG_NODE_INDEX   = 3'd2,
        CFG_MAX_SLOTS    = 3'd3,
        CFG_TX_TARGET    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] merged;
        logic [7:0] held_cnt;
        logic [7:0] rx_cnt;
        logic       diff;
    } lane_res_t;

    typedef struct packed {
        logic held_full;
        logic rx_full;
        logic any_diff;
    } merge_res_t;

    // restart threshold of 6 to 9
    function automatic logic [MISS_W-1:0] draw_limit(input logic [1:0] r);
        return {2'b00, r} + RESTART_RST;
    endfunction

endpackage

// ===== src/flooding_vote_slot_controller.sv =====
// The result of a word is registered and shows in the cycle after the word is accepted.
// Throughput: one word per cycle while the result is taken (m_tready); the byte lanes, the byte-sum
// tree and the slot decision are all combinational, and the result register frees itself as taken.
// Reset (aresetn low, synchronous): clears round state and restores register defaults;
// no result is pending afterwards.
module flooding_vote_slot_controller #(
    parameter int MAX_NODES = fvsc_pkg::MAX_NODES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // slot_state, success, slot_index, rx_proposal, rx_vote_bit, rx_flags,
    // random_value, own_proposal
    input  logic [fvsc_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,   // action
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // next_mode, tx_proposal, tx_vote_bit, tx_flags, report_flags, is_complete,
    // agreed, complete_slot, transmitted, final_slot
    output logic [fvsc_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast,   // round_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fvsc_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [fvsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NUM_LANES = (MAX_NODES + 7) / 8;
    localparam int SUM_W     = $clog2(NUM_LANES * 255 + 1);
    localparam int FLAG_W    = fvsc_pkg::FLAG_W;
    localparam int PROP_W    = fvsc_pkg::PROP_W;
    localparam int SLOT_W    = fvsc_pkg::SLOT_W;
    localparam int DTC_W     = fvsc_pkg::DTC_W;
    localparam int MISS_W    = fvsc_pkg::MISS_W;
    localparam int NODES_W   = fvsc_pkg::NODES_W;
    localparam int INDEX_W   = fvsc_pkg::INDEX_W;

    // input word fields
    logic [1:0]        in_slot_state;
    logic              in_success;
    logic [SLOT_W-1:0] in_slot_index;
    logic [PROP_W-1:0] in_rx_proposal;
    logic              in_rx_vote;
    logic [FLAG_W-1:0] in_rx_flags;
    logic [1:0]        in_rand_low;
    logic [PROP_W-1:0] in_own_proposal;

    assign in_slot_state   = s_tdata[1:0];
    assign in_success      = s_tdata[2];
    assign in_slot_index   = s_tdata[14:3];
    assign in_rx_proposal  = s_tdata[45:15];
    assign in_rx_vote      = s_tdata[46];
    assign in_rx_flags     = s_tdata[110:47];
    assign in_rand_low     = s_tdata[112:111];
    assign in_own_proposal = s_tdata[157:127];

    // configuration
    logic               is_init_reg;
    logic [NODES_W-1:0] node_count_reg;
    logic [INDEX_W-1:0] node_index_reg;
    logic [SLOT_W-1:0]  max_slots_reg;
    logic [DTC_W-1:0]   tx_target_reg;

    // round state
    logic               tx_pending_reg,  tx_pending_next;
    logic               agree_reg,       agree_next;
    logic               did_tx_reg,      did_tx_next;
    logic               complete_reg,    complete_next;
    logic               got_valid_reg,   got_valid_next;
    logic               peer_reg,        peer_next;
    logic [DTC_W-1:0]   dtc_reg,         dtc_next;
    logic [MISS_W-1:0]  miss_reg,        miss_next;
    logic [MISS_W-1:0]  restart_reg,     restart_next;
    logic [PROP_W-1:0]  prop_reg,        prop_next;
    logic               vote_reg,        vote_next;
    logic [FLAG_W-1:0]  flags_reg,       flags_next;
    logic [SLOT_W-1:0]  done_slot_reg,   done_slot_next;
    logic [SLOT_W-1:0]  end_slot_reg,    end_slot_next;

    // result register
    logic                           m_valid_reg, m_valid_next;
    logic [fvsc_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                           out_last_reg, out_last_next;

    logic in_accept;
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // flag window: bytes that count and the all-nodes threshold
    logic [NODES_W-1:0] eff_n;
    logic [NODES_W-1:0] eff_m1;
    logic [2:0]         len_m1;
    logic [3:0]         last_bits;
    logic [7:0]         last_val;
    logic [SUM_W-1:0]   target;

    always_comb begin
        if (node_count_reg == '0) begin
            eff_n = NODES_W'(1);
        end else if (node_count_reg > NODES_W'(MAX_NODES)) begin
            eff_n = NODES_W'(MAX_NODES);
        end else begin
            eff_n = node_count_reg;
        end
        eff_m1    = eff_n - NODES_W'(1);
        len_m1    = eff_m1[5:3];
        last_bits = {1'b0, eff_m1[2:0]} + 4'd1;
        last_val  = 8'((9'd1 << last_bits) - 9'd1);
        target    = SUM_W'({len_m1, 8'h00}) - SUM_W'(len_m1) + SUM_W'(last_val);
    end

    // byte lanes
    fvsc_pkg::lane_res_t  lane_res [NUM_LANES];
    fvsc_pkg::merge_res_t mres;
    logic [NUM_LANES-1:0] lane_en;
    logic [FLAG_W-1:0]    merged_flags;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        assign lane_en[i] = (int'(len_m1) >= i);
        fvsc_lane u_lane (
            .en        (lane_en[i]),
            .held_byte (flags_reg[8*i +: 8]),
            .rx_byte   (in_rx_flags[8*i +: 8]),
            .res       (lane_res[i])
        );
    end

    fvsc_merge #(
        .NUM_LANES (NUM_LANES),
        .SUM_W     (SUM_W)
    ) u_merge (
        .lanes  (lane_res),
        .target (target),
        .res    (mres)
    );

    always_comb begin
        merged_flags = flags_reg;
        for (int i = 0; i < NUM_LANES; i++) begin
            merged_flags[8*i +: 8] = lane_res[i].merged;
        end
    end

    // slot decision
    logic              rx_ok;
    logic [MISS_W-1:0] miss_inc;
    logic [1:0]        nxt;
    logic [FLAG_W-1:0] report;
    logic              round_end;

    always_comb begin
        tx_pending_next = tx_pending_reg;
        agree_next      = agree_reg;
        did_tx_next     = did_tx_reg;
        complete_next   = complete_reg;
        got_valid_next  = got_valid_reg;
        peer_next       = peer_reg;
        dtc_next        = dtc_reg;
        miss_next       = miss_reg;
        restart_next    = restart_reg;
        prop_next       = prop_reg;
        vote_next       = vote_reg;
        flags_next      = flags_reg;
        done_slot_next  = done_slot_reg;
        end_slot_next   = end_slot_reg;
        nxt             = fvsc_pkg::NEXT_RX;
        report          = '0;
        round_end       = 1'b0;
        rx_ok           = (in_slot_state == fvsc_pkg::SLOT_RX) && in_success;
        miss_inc        = (miss_reg == fvsc_pkg::MISS_MAX) ? miss_reg : miss_reg + MISS_W'(1);

        if (s_tuser) begin
            // begin round: clear and reload
            tx_pending_next = 1'b0;
            agree_next      = 1'b0;
            did_tx_next     = 1'b0;
            complete_next   = 1'b0;
            got_valid_next  = 1'b0;
            peer_next       = 1'b0;
            dtc_next        = '0;
            miss_next       = '0;
            end_slot_next   = max_slots_reg;
            done_slot_next  = '0;
            restart_next    = fvsc_pkg::draw_limit(in_rand_low);
            prop_next       = '0;
            vote_next       = 1'b0;
            if (is_init_reg) begin
                prop_next  = in_own_proposal;
                vote_next  = (in_own_proposal != '0);
                agree_next = (in_own_proposal != '0);
            end
            flags_next = FLAG_W'(1) << node_index_reg;
        end else begin
            if (rx_ok && !complete_reg) begin
                got_valid_next = 1'b1;
                if (!got_valid_reg) begin
                    prop_next  = in_rx_proposal;
                    agree_next = (in_rx_proposal != '0);
                end
                vote_next       = in_rx_vote & agree_next;
                tx_pending_next = mres.any_diff;
                flags_next      = merged_flags;
                if (mres.held_full) begin
                    tx_pending_next = 1'b1;
                    done_slot_next  = in_slot_index;
                    complete_next   = 1'b1;
                end
            end else if (rx_ok && mres.rx_full) begin
                peer_next = 1'b1;
            end

            if (is_init_reg && (in_slot_state == fvsc_pkg::SLOT_INIT)) begin
                nxt            = fvsc_pkg::NEXT_TX;
                got_valid_next = 1'b1;
            end else if (rx_ok) begin
                miss_next = '0;
                if (tx_pending_next) begin
                    nxt = fvsc_pkg::NEXT_TX;
                    if (complete_next && (dtc_reg != fvsc_pkg::DTC_MAX)) begin
                        dtc_next = dtc_reg + DTC_W'(1);
                    end
                end
            end else if ((in_slot_state == fvsc_pkg::SLOT_RX) && got_valid_next) begin
                miss_next = miss_inc;
                if (miss_inc > restart_reg) begin
                    // missed too long: restart the flood
                    nxt          = fvsc_pkg::NEXT_TX;
                    miss_next    = '0;
                    restart_next = fvsc_pkg::draw_limit(in_rand_low);
                    if (complete_next && (dtc_reg != fvsc_pkg::DTC_MAX)) begin
                        dtc_next = dtc_reg + DTC_W'(1);
                    end
                end
            end else if ((in_slot_state == fvsc_pkg::SLOT_TX) && !in_success) begin
                got_valid_next = 1'b1;
                nxt            = fvsc_pkg::NEXT_TX;
            end else if ((in_slot_state == fvsc_pkg::SLOT_TX) && peer_next
                         && (dtc_reg >= tx_target_reg)) begin
                nxt = fvsc_pkg::NEXT_OFF;
            end

            report    = (in_slot_state == fvsc_pkg::SLOT_TX) ? flags_next : in_rx_flags;
            round_end = (({1'b0, in_slot_index} + 13'd1) >= {1'b0, max_slots_reg})
                        || (nxt == fvsc_pkg::NEXT_OFF);
            if (round_end) begin
                end_slot_next = in_slot_index;
            end
            if (nxt == fvsc_pkg::NEXT_TX) begin
                did_tx_next = 1'b1;
            end
        end

        out_data_next = {3'b000, end_slot_next, did_tx_next, done_slot_next, agree_next,
                         complete_next, report, flags_next, vote_next, prop_next, nxt};
        out_last_next = round_end;

        if (in_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            is_init_reg    <= 1'b0;
            node_count_reg <= fvsc_pkg::NODE_COUNT_RST;
            node_index_reg <= '0;
            max_slots_reg  <= fvsc_pkg::MAX_SLOTS_RST;
            tx_target_reg  <= fvsc_pkg::TX_TARGET_RST;
            tx_pending_reg <= 1'b0;
            agree_reg      <= 1'b0;
            did_tx_reg     <= 1'b0;
            complete_reg   <= 1'b0;
            got_valid_reg  <= 1'b0;
            peer_reg       <= 1'b0;
            dtc_reg        <= '0;
            miss_reg       <= '0;
            restart_reg    <= fvsc_pkg::RESTART_RST;
            prop_reg       <= '0;
            vote_reg       <= 1'b0;
            flags_reg      <= '0;
            done_slot_reg  <= '0;
            end_slot_reg   <= fvsc_pkg::MAX_SLOTS_RST;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fvsc_pkg::CFG_IS_INITIATOR: is_init_reg    <= cfg_data[0];
                    fvsc_pkg::CFG_NODE_COUNT:   node_count_reg <= cfg_data[NODES_W-1:0];
                    fvsc_pkg::CFG_NODE_INDEX:   node_index_reg <= cfg_data[INDEX_W-1:0];
                    fvsc_pkg::CFG_MAX_SLOTS:    max_slots_reg  <= cfg_data[SLOT_W-1:0];
                    fvsc_pkg::CFG_TX_TARGET:    tx_target_reg  <= cfg_data[DTC_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                tx_pending_reg <= tx_pending_next;
                agree_reg      <= agree_next;
                did_tx_reg     <= did_tx_next;
                complete_reg   <= complete_next;
                got_valid_reg  <= got_valid_next;
                peer_reg       <= peer_next;
                dtc_reg        <= dtc_next;
                miss_reg       <= miss_next;
                restart_reg    <= restart_next;
                prop_reg       <= prop_next;
                vote_reg       <= vote_next;
                flags_reg      <= flags_next;
                done_slot_reg  <= done_slot_next;
                end_slot_reg   <= end_slot_next;
            end
        end
    end

    // payload: load on accept only
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

endmodule

// ===== src/fvsc_lane.sv =====
module fvsc_lane (
    input  logic                 en,
    input  logic [7:0]           held_byte,
    input  logic [7:0]           rx_byte,
    output fvsc_pkg::lane_res_t  res
);

    logic [7:0] rx_masked;

    assign rx_masked    = en ? rx_byte : 8'h00;
    assign res.merged   = held_byte | rx_masked;
    assign res.held_cnt = en ? (held_byte | rx_byte) : 8'h00;
    assign res.rx_cnt   = rx_masked;
    assign res.diff     = en && (rx_byte != held_byte);

endmodule

// ===== src/fvsc_merge.sv =====
module fvsc_merge #(
    parameter int NUM_LANES = 8,
    parameter int SUM_W     = 11
) (
    input  fvsc_pkg::lane_res_t  lanes [NUM_LANES],
    input  logic [SUM_W-1:0]     target,
    output fvsc_pkg::merge_res_t res
);

    logic [SUM_W-1:0] held_sum;
    logic [SUM_W-1:0] rx_sum;
    logic             diff_any;

    always_comb begin
        held_sum = '0;
        rx_sum   = '0;
        diff_any = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            held_sum = held_sum + SUM_W'(lanes[i].held_cnt);
            rx_sum   = rx_sum + SUM_W'(lanes[i].rx_cnt);
            diff_any = diff_any | lanes[i].diff;
        end
    end

    assign res.held_full = (held_sum >= target);
    assign res.rx_full   = (rx_sum >= target);
    assign res.any_diff  = diff_any;

endmodule

// ===== src/fvsc_checker.sv =====
module fvsc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fvsc_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word pending after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // round begin answers with a clean receive result in the next cycle
    a_begin: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=>
            m_tvalid && (m_tdata[1:0] == fvsc_pkg::NEXT_RX) && !m_tlast
            && !m_tdata[fvsc_pkg::OUT_COMPLETE_BIT] && !m_tdata[fvsc_pkg::OUT_XMIT_BIT])
        else $error("round begin result wrong");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == fvsc_pkg::NEXT_RX) || (m_tdata[1:0] == fvsc_pkg::NEXT_TX)
                     || (m_tdata[1:0] == fvsc_pkg::NEXT_OFF))
        else $error("next state code out of range");

    // going off always ends the round
    a_off_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == fvsc_pkg::NEXT_OFF) |-> m_tlast)
        else $error("off without round end");

endmodule

bind flooding_vote_slot_controller fvsc_checker u_fvsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
